// ===== src/ped_pkg.sv =====
// Shared types and constants for the palette error-diffusion ditherer.
`default_nettype none
package ped_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PAL_DEPTH_DEF = 256;
    localparam int CH_W          = 8;
    localparam int ERR_W         = 13;
    localparam int DIST_W        = 20;
    localparam int CFG_W         = 20;
    localparam int CFG_IDX_W     = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_ENTRIES = 2'd2,
        CFG_THRESH  = 2'd3
    } t_cfg_idx;

    // input action codes
    localparam logic ACT_PAL_WR = 1'b0;
    localparam logic ACT_PIXEL  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  entry_index;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
    } t_in;

    typedef struct packed {
        logic [7:0]  palette_index;
        logic        frame_end;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic pal_wr;
        logic pix_ld;
        logic err_rd;
        logic p1_clr;
        logic p2_clr;
        logic iss_vld;
        logic iss_pass;
        logic cur_ld;
        logic upd;
        logic wr_last;
        logic res_ld;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic found;
        logic last_col;
    } t_stat;
endpackage
`default_nettype wire

// ===== src/ped_ctrl.sv =====
// Sequencing state machine for one pixel's search and error update.
`default_nettype none
module ped_ctrl import ped_pkg::*; #(
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF,
    localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_action,
    output logic               o_in_ready,
    input  wire logic [8:0]    i_entries,
    input  wire logic          i_out_free,
    input  wire t_stat         i_stat,
    output t_cmd               o_cmd,
    output logic [PW-1:0]      o_iss_idx
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_ERRD = 10'b0000000010,
        S_P1   = 10'b0000000100,
        S_P1W  = 10'b0000001000,
        S_CUR  = 10'b0000010000,
        S_P2   = 10'b0000100000,
        S_P2W  = 10'b0001000000,
        S_UPD  = 10'b0010000000,
        S_WRL  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state         r_state, n_state;
    logic [PW:0]    r_cnt, n_cnt;
    logic [PW:0]    w_n_eff;
    logic           w_last_iss;
    logic           w_accept;

    // effective number of entries searched
    always_comb begin
        if (i_entries == 9'd0) begin
            w_n_eff = (PW+1)'(1);
        end else if (10'(i_entries) > 10'(PALETTE_DEPTH)) begin
            w_n_eff = (PW+1)'(PALETTE_DEPTH);
        end else begin
            w_n_eff = (PW+1)'(i_entries);
        end
    end

    assign w_last_iss = (r_cnt + (PW+1)'(1)) >= w_n_eff;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    assign o_iss_idx  = r_cnt[PW-1:0];

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_PAL_WR) begin
                        o_cmd.pal_wr = 1'b1;
                    end else begin
                        o_cmd.pix_ld = 1'b1;
                        n_state = S_ERRD;
                    end
                end
            end
            S_ERRD: begin
                o_cmd.err_rd = 1'b1;
                o_cmd.p1_clr = 1'b1;
                n_cnt = '0;
                n_state = S_P1;
            end
            S_P1: begin
                if (i_stat.found) begin
                    n_state = S_P1W;
                end else begin
                    o_cmd.iss_vld = 1'b1;
                    n_cnt = r_cnt + (PW+1)'(1);
                    if (w_last_iss) n_state = S_P1W;
                end
            end
            S_P1W: begin
                if (!i_stat.pipe_busy) begin
                    n_state = i_stat.found ? S_UPD : S_CUR;
                end
            end
            S_CUR: begin
                o_cmd.cur_ld = 1'b1;
                o_cmd.p2_clr = 1'b1;
                n_cnt = '0;
                n_state = S_P2;
            end
            S_P2: begin
                o_cmd.iss_vld  = 1'b1;
                o_cmd.iss_pass = 1'b1;
                n_cnt = r_cnt + (PW+1)'(1);
                if (w_last_iss) n_state = S_P2W;
            end
            S_P2W: begin
                if (!i_stat.pipe_busy) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = i_stat.last_col ? S_WRL : S_DONE;
            end
            S_WRL: begin
                o_cmd.wr_last = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.res_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // result only loads into a free output register
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_ld |-> i_out_free)
        else $error("result loaded while output register full");
    // error update only after the search pipeline has drained
    a_upd_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |-> !i_stat.pipe_busy)
        else $error("update while search pipeline busy");
    // the row-end write directly follows the update
    a_wrl_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_last |-> $past(o_cmd.upd))
        else $error("row-end write without update");
endmodule
`default_nettype wire

// ===== src/ped_dpath.sv =====
// Palette store, distance unit, error row buffers and diffusion arithmetic.
`default_nettype none
module ped_dpath import ped_pkg::*; #(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF,
    localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1,
    localparam int XW = $clog2(MAX_WIDTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [PW-1:0]     i_iss_idx,
    input  wire t_in               i_in,
    input  wire logic [10:0]       i_width,
    input  wire logic [15:0]       i_height,
    input  wire logic [DIST_W-1:0] i_thresh,
    output t_stat                  o_stat,
    output logic [7:0]             o_best,
    output logic                   o_frame_end
);
    localparam int EW = 4 * ERR_W;

    logic [31:0]           r_pal [2**PW];
    logic [EW-1:0]         r_err [2**(XW+1)];

    logic [31:0]           r_pix, r_cur;
    logic [EW-1:0]         r_err_q;
    logic [EW-1:0]         r_carry, r_acc_prev, r_acc_cur;
    logic                  r_bank;
    logic [XW:0]           r_fill;
    logic [XW-1:0]         r_col;
    logic [15:0]           r_row;

    logic                  r_a_vld, r_a_pass;
    logic [PW-1:0]         r_a_idx;
    logic [31:0]           r_a_data;
    logic                  r_b_vld, r_b_pass;
    logic [PW-1:0]         r_b_idx;
    logic [31:0]           r_b_data;
    logic [DIST_W-1:0]     r_dist;

    logic                  r_found;
    logic [PW-1:0]         r_best;
    logic [DIST_W-1:0]     r_bestd;
    logic [31:0]           r_best_ent;

    logic                  w_last_col, w_last_row;
    logic [31:0]           w_op;
    logic [DIST_W-1:0]     w_dist;
    logic [31:0]           w_cur;
    logic [EW-1:0]         w_carry, w_acc_prev, w_acc_cur, w_acc_next;
    logic [XW-1:0]         w_col_m1;

    // position flags
    assign w_last_col = (16'(r_col) + 16'd1 >= 16'(i_width)) ||
                        (r_col == XW'(MAX_WIDTH - 1));
    assign w_last_row = (17'(r_row) + 17'd1) >= 17'(i_height);
    assign w_col_m1   = r_col - XW'(1);

    assign o_stat.pipe_busy = r_a_vld || r_b_vld;
    assign o_stat.found     = r_found;
    assign o_stat.last_col  = w_last_col;
    assign o_best           = 8'(r_best);
    assign o_frame_end      = w_last_col && w_last_row;

    // palette store: written by palette transactions, read by the search
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr && (9'(i_in.entry_index) < 9'(PALETTE_DEPTH))) begin
            r_pal[i_in.entry_index[PW-1:0]] <=
                {i_in.alpha, i_in.red, i_in.green, i_in.blue};
        end
        if (i_cmd.iss_vld) begin
            r_a_data <= r_pal[i_iss_idx];
        end
    end

    // weighted distance 2,4,3,1 over blue, green, red, alpha
    assign w_op = r_a_pass ? r_cur : r_pix;
    always_comb begin
        logic signed [8:0]  d;
        logic        [15:0] sq;
        logic        [DIST_W-1:0] s;
        s = '0;
        for (int c = 0; c < 4; c++) begin
            d  = $signed({1'b0, w_op[8*c +: 8]}) - $signed({1'b0, r_a_data[8*c +: 8]});
            sq = 16'(d * d);
            case (c)
                0: s = s + {3'b0, sq, 1'b0};
                1: s = s + {2'b0, sq, 2'b0};
                2: s = s + {3'b0, sq, 1'b0} + {4'b0, sq};
                default: s = s + {4'b0, sq};
            endcase
        end
        w_dist = s;
    end

    // search pipeline: read, distance, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.iss_vld;
            r_b_vld <= r_a_vld;
            if (i_cmd.p1_clr) begin
                r_found <= 1'b0;
            end else if (r_b_vld && !r_b_pass && !r_found && (r_dist < i_thresh)) begin
                r_found <= 1'b1;
            end
        end
        r_a_pass <= i_cmd.iss_pass;
        r_a_idx  <= i_iss_idx;
        r_b_pass <= r_a_pass;
        r_b_idx  <= r_a_idx;
        r_b_data <= r_a_data;
        r_dist   <= w_dist;
        if (i_cmd.p1_clr) begin
            r_best <= '0;
        end else if (i_cmd.p2_clr) begin
            r_bestd <= '1;
        end else if (r_b_vld && !r_b_pass && !r_found && (r_dist < i_thresh)) begin
            r_best <= r_b_idx;
        end else if (r_b_vld && r_b_pass && (r_dist < r_bestd)) begin
            r_bestd    <= r_dist;
            r_best     <= r_b_idx;
            r_best_ent <= r_b_data;
        end
    end

    // working pixel: original plus diffused error, clamped and rounded
    always_comb begin
        logic signed [15:0] v;
        logic        [EW-1:0] e_this;
        e_this = ({1'b0, r_col} < r_fill) ? r_err_q : '0;
        for (int c = 0; c < 4; c++) begin
            v = $signed({4'b0, r_pix[8*c +: 8], 4'b0})
              + 16'($signed(e_this[ERR_W*c +: ERR_W]))
              + 16'($signed(r_carry[ERR_W*c +: ERR_W]));
            if (v < 0) v = 16'sd0;
            if (v > 16'sd4080) v = 16'sd4080;
            v = v + 16'sd8;
            w_cur[8*c +: 8] = v[11:4];
        end
    end

    // error shares of the chosen entry
    always_comb begin
        logic signed [ERR_W-1:0] e;
        for (int c = 0; c < 4; c++) begin
            if (r_found) begin
                e = '0;
            end else begin
                e = ERR_W'($signed({1'b0, r_cur[8*c +: 8]}) -
                           $signed({1'b0, r_best_ent[8*c +: 8]}));
            end
            w_carry[ERR_W*c +: ERR_W] = w_last_col ? '0 : ERR_W'((e <<< 3) - e);
            w_acc_prev[ERR_W*c +: ERR_W] = r_acc_prev[ERR_W*c +: ERR_W] +
                (w_last_row ? ERR_W'(0) : ERR_W'((e <<< 1) + e));
            w_acc_cur[ERR_W*c +: ERR_W] = r_acc_cur[ERR_W*c +: ERR_W] +
                (w_last_row ? ERR_W'(0) : ERR_W'((e <<< 2) + e));
            w_acc_next[ERR_W*c +: ERR_W] = (w_last_row || w_last_col) ? '0 : e;
        end
    end

    // error row buffers, two banks; the next-row bank fills in column order
    always_ff @(posedge i_clk) begin
        if (i_cmd.err_rd) begin
            r_err_q <= r_err[{r_bank, r_col}];
        end
        if (i_cmd.upd && (r_col != '0)) begin
            r_err[{~r_bank, w_col_m1}] <= w_acc_prev;
        end else if (i_cmd.wr_last) begin
            r_err[{~r_bank, r_col}] <= r_acc_prev;
        end
    end

    // pixel and working value
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_ld) r_pix <= {i_in.alpha, i_in.red, i_in.green, i_in.blue};
        if (i_cmd.cur_ld) r_cur <= w_cur;
    end

    // diffusion state and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry    <= '0;
            r_acc_prev <= '0;
            r_acc_cur  <= '0;
            r_bank     <= 1'b0;
            r_fill     <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cmd.upd) begin
            r_carry    <= w_carry;
            r_acc_prev <= w_acc_cur;
            r_acc_cur  <= w_acc_next;
        end else if (i_cmd.res_ld) begin
            if (w_last_col) begin
                r_col      <= '0;
                r_carry    <= '0;
                r_acc_prev <= '0;
                r_acc_cur  <= '0;
                r_bank     <= ~r_bank;
                if (w_last_row) begin
                    r_row  <= '0;
                    r_fill <= '0;
                end else begin
                    r_row  <= r_row + 16'd1;
                    r_fill <= {1'b0, r_col} + (XW+1)'(1);
                end
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/palette_error_diffusion_ditherer_top.sv =====
// Top level: configuration registers, output register, controller and datapath.
// Each pixel searches N entries in two passes through the single palette read port
// and shared distance unit (one entry per cycle), with an extra write at a row end;
// a close match ends the first pass early and skips the second. A new pixel is
// accepted only after the previous result is loaded; palette writes give no result.
// Reset (synchronous, active low) restores register defaults and clears error carries.
`default_nettype none
module palette_error_diffusion_ditherer_top import ped_pkg::*; #(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [10:0]       r_width;
    logic [15:0]       r_height;
    logic [8:0]        r_entries;
    logic [DIST_W-1:0] r_thresh;
    logic              r_out_vld;
    t_out              r_out;
    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [PW-1:0]     w_iss_idx;
    logic [7:0]        w_best;
    logic              w_frame_end;
    logic              w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 11'd1024;
            r_height  <= 16'd1;
            r_entries <= 9'd256;
            r_thresh  <= DIST_W'(16);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:   r_width   <= i_cfg_data[10:0];
                CFG_HEIGHT:  r_height  <= i_cfg_data[15:0];
                CFG_ENTRIES: r_entries <= i_cfg_data[8:0];
                CFG_THRESH:  r_thresh  <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // output register
    assign w_out_free = !r_out_vld || i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_cmd.res_ld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_cmd.res_ld) begin
            r_out.palette_index <= w_best;
            r_out.frame_end     <= w_frame_end;
        end
    end
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    ped_ctrl #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_ready (o_in_ready),
        .i_entries  (r_entries),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_iss_idx  (w_iss_idx)
    );

    ped_dpath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_iss_idx   (w_iss_idx),
        .i_in        (i_in_data),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_thresh    (r_thresh),
        .o_stat      (w_stat),
        .o_best      (w_best),
        .o_frame_end (w_frame_end)
    );
endmodule
`default_nettype wire
